/* hw/rtl/mscc_pkg.sv */
package mscc_pkg;

    localparam int LEN_W   = 12;
    localparam int TDATA_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [LEN_W-1:0] len_t;

    // One table entry: reachable flag over the best piece count.
    typedef struct packed {
        logic valid;
        len_t count;
    } entry_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIECE_A = 2'd0,
        CFG_PIECE_B = 2'd1,
        CFG_PIECE_C = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FETCH,
        ST_PUT
    } state_t;

endpackage

/* hw/rtl/mscc_ram.sv */
module mscc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* hw/rtl/mscc_dp.sv */
// Table datapath: issue three reads for entry idx, compute and write it back
// in the next cycle. A read that hits the entry written on the same edge takes
// the forwarded value.
module mscc_dp #(
    parameter int MAX_LENGTH = 4095
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  logic [$clog2(MAX_LENGTH+1)-1:0] idx,
    input  mscc_pkg::len_t                piece_a,
    input  mscc_pkg::len_t                piece_b,
    input  mscc_pkg::len_t                piece_c,
    input  logic [$clog2(MAX_LENGTH+1)-1:0] total_addr,
    output mscc_pkg::entry_t              total_entry
);

    localparam int DEPTH = MAX_LENGTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (AW > mscc_pkg::LEN_W) ? AW : mscc_pkg::LEN_W;
    localparam int NP    = 3;

    mscc_pkg::len_t   piece [NP];
    logic [XW:0]      diff  [NP];
    logic [AW-1:0]    raddr [NP];
    logic             use_n [NP];
    logic             hit_n [NP];
    mscc_pkg::entry_t rdata [NP];
    mscc_pkg::entry_t ent   [NP];

    logic             c_valid_reg;
    logic [AW-1:0]    c_idx_reg;
    logic             use_reg [NP];
    logic             hit_reg [NP];
    mscc_pkg::entry_t fwd_reg;

    logic             wr_en;
    mscc_pkg::entry_t wr_data;
    logic             ok;
    logic [mscc_pkg::LEN_W:0] best;
    logic [mscc_pkg::LEN_W:0] cand;

    assign piece[0] = piece_a;
    assign piece[1] = piece_b;
    assign piece[2] = piece_c;

    // read side: address idx - piece, skipped when the piece is zero or does not fit
    always_comb
    begin
        for (int k = 0; k < NP; k++)
        begin
            diff[k]  = {1'b0, XW'(idx)} - {1'b0, XW'(piece[k])};
            raddr[k] = diff[k][AW-1:0];
            use_n[k] = (piece[k] != '0) && !diff[k][XW];
            hit_n[k] = c_valid_reg && (raddr[k] == c_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        c_idx_reg <= idx;
        for (int k = 0; k < NP; k++)
        begin
            use_reg[k] <= use_n[k];
            hit_reg[k] <= hit_n[k];
        end
        if (c_valid_reg)
        begin
            fwd_reg <= wr_data;
        end
    end

    // compute side: max over reachable predecessors, plus one; entry 0 is reachable with count 0
    always_comb
    begin
        ok   = 1'b0;
        best = '0;
        cand = '0;
        for (int k = 0; k < NP; k++)
        begin
            ent[k] = hit_reg[k] ? fwd_reg : rdata[k];
            if (use_reg[k] && ent[k].valid)
            begin
                cand = {1'b0, ent[k].count} + 1'b1;
                if (!ok || (cand > best))
                begin
                    best = cand;
                    ok   = 1'b1;
                end
            end
        end
        if (c_idx_reg == '0)
        begin
            wr_data.valid = 1'b1;
            wr_data.count = '0;
        end
        else
        begin
            wr_data.valid = ok;
            wr_data.count = best[mscc_pkg::LEN_W-1:0];
        end
    end

    assign wr_en = c_valid_reg;

    mscc_ram #(
        .WIDTH ($bits(mscc_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram_ab (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (c_idx_reg),
        .wr_data   (wr_data),
        .rd_addr_a (raddr[0]),
        .rd_data_a (rdata[0]),
        .rd_addr_b (raddr[1]),
        .rd_data_b (rdata[1])
    );

    // second copy: third piece plus the final readout
    mscc_ram #(
        .WIDTH ($bits(mscc_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram_c (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (c_idx_reg),
        .wr_data   (wr_data),
        .rd_addr_a (raddr[2]),
        .rd_data_a (rdata[2]),
        .rd_addr_b (total_addr),
        .rd_data_b (total_entry)
    );

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && $past(c_valid_reg) |-> c_idx_reg == AW'($past(c_idx_reg) + 1'b1))
        else $error("table write index skipped or repeated");

    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (c_idx_reg == '0) |-> wr_data.valid && (wr_data.count == '0))
        else $error("entry zero not written as reachable with count zero");

    a_fwd_dir: assert property (@(posedge clk) disable iff (!rst_n)
        issue && c_valid_reg && use_n[0] |-> raddr[0] <= c_idx_reg)
        else $error("read ahead of the last written entry");

endmodule

/* hw/rtl/max_segment_cut_count.sv */
// Channel | Dir | Fields (lsb first)              | Transfer when
// --------+-----+---------------------------------+-------------------------
// s_axis  | in  | tdata: total_length[11:0]       | s_tvalid && s_tready
// m_axis  | out | tdata: segment_count[11:0]      | m_tvalid && m_tready
// cfg     | in  | cfg_index[1:0], cfg_data[11:0]  | cfg_valid && cfg_ready
//
// Each item sweeps the table from entry 0 to total_length, one table entry
// per cycle, set by the three reads per entry served from two dual-read table
// copies, then passes through drain, readout and output load before m_tvalid.
// A total above MAX_LENGTH skips the sweep and answers 0.
// Reset clears control and loads every piece length with 1; the table is not
// cleared, each item rewrites entries 0..total before reading them.
// One item at a time; the next is taken while a result waits in the output
// register, and a stalled output only holds the block at the final load.
module max_segment_cut_count #(
    parameter int MAX_LENGTH = 4095
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mscc_pkg::TDATA_W-1:0]        s_tdata,   // total_length[11:0], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mscc_pkg::TDATA_W-1:0]        m_tdata,   // segment_count[11:0], zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mscc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  mscc_pkg::len_t                      cfg_data
);

    localparam int AW = $clog2(MAX_LENGTH + 1);

    mscc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    mscc_pkg::len_t   total_reg, total_next;
    logic             over_reg, over_next;
    mscc_pkg::len_t   piece_a_reg, piece_b_reg, piece_c_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    mscc_pkg::len_t   count_reg, count_next;

    logic             in_xfer;
    logic             issue;
    logic             load_out;
    logic [AW-1:0]    total_addr;
    mscc_pkg::entry_t total_entry;
    mscc_pkg::len_t   in_total;
    mscc_pkg::len_t   result;

    assign in_total   = s_tdata[mscc_pkg::LEN_W-1:0];
    assign in_xfer    = s_tvalid && s_tready;
    assign total_addr = AW'(total_reg);
    assign cfg_ready  = 1'b1;

    // configuration: indexes past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_a_reg <= mscc_pkg::len_t'(1);
            piece_b_reg <= mscc_pkg::len_t'(1);
            piece_c_reg <= mscc_pkg::len_t'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mscc_pkg::CFG_PIECE_A: piece_a_reg <= cfg_data;
                mscc_pkg::CFG_PIECE_B: piece_b_reg <= cfg_data;
                mscc_pkg::CFG_PIECE_C: piece_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mscc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        total_reg <= total_next;
        over_reg  <= over_next;
        count_reg <= count_next;
    end

    // table answer, forced to 0 when out of range or unreachable
    assign result = (over_reg || !total_entry.valid) ? '0 : total_entry.count;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        over_next     = over_reg;
        count_next    = count_reg;
        s_tready      = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            mscc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer)
                begin
                    total_next = in_total;
                    idx_next   = '0;
                    over_next  = 32'(in_total) > 32'(MAX_LENGTH);
                    state_next = over_next ? mscc_pkg::ST_PUT : mscc_pkg::ST_SWEEP;
                end
            end
            mscc_pkg::ST_SWEEP:
            begin
                issue    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == total_addr)
                begin
                    state_next = mscc_pkg::ST_DRAIN;
                end
            end
            mscc_pkg::ST_DRAIN:
            begin
                // last entry is written at the end of this cycle
                state_next = mscc_pkg::ST_FETCH;
            end
            mscc_pkg::ST_FETCH:
            begin
                // readout port samples the finished entry
                state_next = mscc_pkg::ST_PUT;
            end
            mscc_pkg::ST_PUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    count_next    = result;
                    m_tvalid_next = 1'b1;
                    state_next    = mscc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mscc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mscc_pkg::TDATA_W - mscc_pkg::LEN_W){1'b0}}, count_reg};

    mscc_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .idx         (idx_reg),
        .piece_a     (piece_a_reg),
        .piece_b     (piece_b_reg),
        .piece_c     (piece_c_reg),
        .total_addr  (total_addr),
        .total_entry (total_entry)
    );

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mscc_pkg::ST_SWEEP |-> idx_reg <= total_addr)
        else $error("sweep index passed the requested total");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == mscc_pkg::ST_SWEEP || state_reg == mscc_pkg::ST_PUT)
        else $error("input transfer did not start an item");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(load_out))
        else $error("result raised without an output load");

endmodule

/* sim/tb_max_segment_cut_count.sv */
`timescale 1ns / 1ps

module tb_max_segment_cut_count;

    localparam int MAX_LEN      = 4095;
    localparam int IDLE_PCT     = 29;
    localparam int SETTLE_CYCLES = 16;
    // Worst case: ~145 items at the full 4095 sweep, plus gaps and stalls, x4.
    localparam int CYCLE_LIMIT  = 2_500_000;
    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [mscc_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the piece lengths and the count table, predicts
    // the count for every length transfer and checks results in order.
    // ------------------------------------------------------------------
    class cut_scoreboard;
        mscc_pkg::len_t   piece_len [3];
        mscc_pkg::entry_t cut_table [MAX_LEN+1];
        mscc_pkg::len_t   expected_counts [$];
        int               errors;

        function new();
            piece_len = '{default: mscc_pkg::len_t'(1)};
            foreach (cut_table[i]) cut_table[i] = '0;
            errors = 0;
        endfunction

        function void set_piece(logic [mscc_pkg::CFG_IDX_W-1:0] idx, mscc_pkg::len_t value);
            case (idx)
                mscc_pkg::CFG_PIECE_A: piece_len[0] = value;
                mscc_pkg::CFG_PIECE_B: piece_len[1] = value;
                mscc_pkg::CFG_PIECE_C: piece_len[2] = value;
                default: ;  // no register here
            endcase
        endfunction

        // Bottom-up sweep over 0..total; zero-length pieces never count.
        function mscc_pkg::len_t best_cut_count(mscc_pkg::len_t total);
            bit          ok;
            int unsigned best;
            int unsigned piece;
            int unsigned cand;
            if (int'(total) > MAX_LEN)
                return '0;
            cut_table[0].valid = 1'b1;
            cut_table[0].count = '0;
            for (int i = 1; i <= int'(total); i++)
            begin
                ok   = 1'b0;
                best = 0;
                for (int p = 0; p < 3; p++)
                begin
                    piece = piece_len[p];
                    if (piece != 0 && piece <= i && cut_table[i-piece].valid)
                    begin
                        cand = int'(cut_table[i-piece].count) + 1;
                        if (!ok || cand > best)
                        begin
                            best = cand;
                            ok   = 1'b1;
                        end
                    end
                end
                cut_table[i].valid = ok;
                cut_table[i].count = mscc_pkg::len_t'(best);
            end
            return cut_table[total].valid ? cut_table[total].count : '0;
        endfunction

        function void note_length(mscc_pkg::len_t total);
            expected_counts.push_back(best_cut_count(total));
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_count(mscc_pkg::len_t got);
            mscc_pkg::len_t want;
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected segment_count %0d", got));
                return;
            end
            want = expected_counts.pop_front();
            if (got !== want)
                report_mismatch($sformatf("segment_count %0d, want %0d", got, want));
        endtask

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mscc_pkg::TDATA_W-1:0]   s_tdata = '0;      // total_length[11:0], zero pad
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mscc_pkg::TDATA_W-1:0]   m_tdata;           // segment_count[11:0], zero pad
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mscc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    mscc_pkg::len_t                 cfg_data = '0;

    cut_scoreboard sb = new();
    bit            steady = 1'b0;   // set: neither side idles
    int            cycles = 0;

    max_segment_cut_count DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stalls at random unless in the steady stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor; inputs move on negedge so posedge sampling is clean.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_count(mscc_pkg::len_t'(m_tdata[mscc_pkg::LEN_W-1:0]));
    end

    // ------------------------------------------------------------------
    // Drivers. All called at a falling edge and return at one. Valid
    // lines drop only in the caller or before a gap, so a back-to-back
    // transfer never sees a low and a high assignment in the same step.
    // ------------------------------------------------------------------
    task automatic offer_length(mscc_pkg::len_t total);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            // mostly short gaps, now and then one that spans much of a sweep
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 60)) @(negedge clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mscc_pkg::TDATA_W'(total);
        do @(posedge clk); while (!s_tready);
        sb.note_length(total);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [mscc_pkg::CFG_IDX_W-1:0] idx, mscc_pkg::len_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_piece(idx, value);
        @(negedge clk);
    endtask

    // Let every outstanding result come back, then a few quiet cycles.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_pieces(mscc_pkg::len_t a, mscc_pkg::len_t b, mscc_pkg::len_t c);
        wait_idle();
        write_reg(mscc_pkg::CFG_PIECE_A, a);
        write_reg(mscc_pkg::CFG_PIECE_B, b);
        write_reg(mscc_pkg::CFG_PIECE_C, c);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short pieces so cuts exist; sometimes anything in range.
    function automatic mscc_pkg::len_t pick_piece();
        if ($urandom_range(0, 99) < 80)
            return mscc_pkg::len_t'($urandom_range(1, 16));
        return mscc_pkg::len_t'($urandom_range(1, MAX_LEN));
    endfunction

    // Long sweeps are slow: keep most totals small.
    function automatic mscc_pkg::len_t pick_total();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return mscc_pkg::len_t'($urandom_range(0, 64));
        if (roll < 95)
            return mscc_pkg::len_t'($urandom_range(65, 600));
        return mscc_pkg::len_t'($urandom_range(601, MAX_LEN));
    endfunction

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset lengths (all 1): count equals the total; zero and full range.
        offer_length(mscc_pkg::len_t'(0));
        offer_length(mscc_pkg::len_t'(1));
        offer_length(mscc_pkg::len_t'(MAX_LEN));
        offer_length(mscc_pkg::len_t'(7));

        // Largest pieces: only 0 and 4095 can be filled.
        set_pieces(mscc_pkg::len_t'(MAX_LEN), mscc_pkg::len_t'(MAX_LEN),
                   mscc_pkg::len_t'(MAX_LEN));
        offer_length(mscc_pkg::len_t'(MAX_LEN));
        offer_length(mscc_pkg::len_t'(MAX_LEN - 1));
        offer_length(mscc_pkg::len_t'(0));

        // Mixed pieces with unreachable short totals; a write to the
        // unused index must leave the lengths alone.
        set_pieces(mscc_pkg::len_t'(3), mscc_pkg::len_t'(5), mscc_pkg::len_t'(7));
        write_reg(CFG_NO_REG, mscc_pkg::len_t'(1));
        cfg_valid <= 1'b0;
        offer_length(mscc_pkg::len_t'(1));
        offer_length(mscc_pkg::len_t'(2));
        offer_length(mscc_pkg::len_t'(3));
        offer_length(mscc_pkg::len_t'(8));
        offer_length(mscc_pkg::len_t'(11));
        offer_length(mscc_pkg::len_t'(MAX_LEN));

        // A zero-length piece takes no part in any entry.
        set_pieces(mscc_pkg::len_t'(0), mscc_pkg::len_t'(4), mscc_pkg::len_t'(6));
        offer_length(mscc_pkg::len_t'(4));
        offer_length(mscc_pkg::len_t'(5));
        offer_length(mscc_pkg::len_t'(10));
        offer_length(mscc_pkg::len_t'(12));
        offer_length(mscc_pkg::len_t'(0));

        // Random phases, each with fresh piece lengths; the third runs
        // with neither side idling.
        for (int ph = 0; ph < 5; ph++)
        begin
            set_pieces(pick_piece(), pick_piece(), pick_piece());
            steady = (ph == 2);
            repeat (25) offer_length(pick_total());
        end
        steady = 1'b0;

        wait_idle();
        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding");

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
